[design/ght_pkg.sv]
package ght_pkg;

    // table geometry
    localparam int SLOTS = 64;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // field widths
    localparam int DESC_W = 32;
    localparam int GEN_W  = 64;
    localparam int MASK_W = 4;
    localparam int TAG_W  = 32;
    localparam int INT_W  = 2;

    // opcodes
    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_MODIFY   = 2'd1;
    localparam logic [1:0] OP_REMOVE   = 2'd2;
    localparam logic [1:0] OP_CHECK    = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_STALE   = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ght_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_last;
    } ght_stat_t;

endpackage

[design/ght_ram.sv]
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/ght_ctrl.sv]
module ght_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ght_pkg::ght_stat_t stat,
    output ght_pkg::ght_cmd_t  cmd
);

    import ght_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // output register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // commit never overwrites a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("commit while output register busy");

    // a new result only appears right after the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done state");

    // a waiting result stays until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("result dropped before transfer");
`endif

endmodule

[design/ght_dp.sv]
module ght_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ght_pkg::ght_cmd_t               cmd,
    output ght_pkg::ght_stat_t              stat,
    input  logic [1:0]                      opcode,
    input  logic [ght_pkg::DESC_W-1:0]      descriptor,
    input  logic [ght_pkg::MASK_W-1:0]      interest_mask,
    input  logic [ght_pkg::TAG_W-1:0]       user_tag,
    input  logic [ght_pkg::GEN_W-1:0]       token_generation,
    output logic [1:0]                      status,
    output logic [ght_pkg::GEN_W-1:0]       issued_generation
);

    import ght_pkg::*;

    localparam int ENTRY_W = DESC_W + GEN_W;
    localparam int META_W  = INT_W + TAG_W;

    // captured item
    logic [1:0]        op_reg;
    logic [DESC_W-1:0] desc_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [GEN_W-1:0]  gen_reg;

    // scan pipeline
    logic [IDX_W-1:0]  addr_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              cmp_vld_reg;

    // scan results
    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic              gen_eq_reg;
    logic              free_reg;
    logic [IDX_W-1:0]  free_idx_reg;

    // table state in flops
    logic [SLOTS-1:0]  valid_reg;
    logic [GEN_W-1:0]  ctr_reg;

    // ram signals
    logic [ENTRY_W-1:0] entry_rdata;
    logic [DESC_W-1:0]  rd_desc;
    logic [GEN_W-1:0]   rd_gen;
    logic               entry_we;
    logic               meta_we;
    logic [IDX_W-1:0]   meta_waddr;

    // decision logic
    logic              neg;
    logic              mask_ok;
    logic              tok_ok;
    logic              reg_ok;
    logic              mod_ok;
    logic              rem_ok;
    logic [1:0]        status_next;

    // descriptor and generation per slot
    ght_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (entry_we),
        .waddr (free_idx_reg),
        .wdata ({desc_reg, ctr_reg}),
        .raddr (addr_reg),
        .rdata (entry_rdata)
    );

    // interest mask and user tag per slot
    ght_ram #(
        .WIDTH (META_W),
        .DEPTH (SLOTS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata ({mask_reg[INT_W-1:0], tag_reg}),
        .raddr (meta_waddr),
        .rdata ()
    );

    assign rd_desc = entry_rdata[ENTRY_W-1:GEN_W];
    assign rd_gen  = entry_rdata[GEN_W-1:0];

    assign stat.scan_last = (addr_reg == IDX_W'(SLOTS - 1));

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            desc_reg <= descriptor;
            mask_reg <= interest_mask;
            tag_reg  <= user_tag;
            gen_reg  <= token_generation;
        end
    end

    // scan address and compare stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg    <= '0;
            cmp_idx_reg <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= cmd.scan;
            cmp_idx_reg <= addr_reg;
            if (cmd.load)
            begin
                addr_reg <= '0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan && !stat.scan_last)
                begin
                    addr_reg <= addr_reg + IDX_W'(1);
                end
                if (cmp_vld_reg)
                begin
                    if (valid_reg[cmp_idx_reg] && rd_desc == desc_reg && !hit_reg)
                    begin
                        hit_reg <= 1'b1;
                    end
                    if (!valid_reg[cmp_idx_reg] && !free_reg)
                    begin
                        free_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // first match and first free slot
    always_ff @(posedge clk)
    begin
        if (cmp_vld_reg && !cmd.load)
        begin
            if (valid_reg[cmp_idx_reg] && rd_desc == desc_reg && !hit_reg)
            begin
                hit_idx_reg <= cmp_idx_reg;
                gen_eq_reg  <= (rd_gen == gen_reg);
            end
            if (!valid_reg[cmp_idx_reg] && !free_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
    end

    // outcome of the operation
    always_comb
    begin
        neg     = desc_reg[DESC_W-1];
        mask_ok = (mask_reg != '0) && (mask_reg[MASK_W-1:INT_W] == '0);
        tok_ok  = !neg && hit_reg && gen_eq_reg;
        reg_ok  = 1'b0;
        mod_ok  = 1'b0;
        rem_ok  = 1'b0;
        case (op_reg)
            OP_REGISTER:
            begin
                if (neg || !mask_ok || hit_reg)
                begin
                    status_next = ST_INVALID;
                end
                else if (!free_reg)
                begin
                    status_next = ST_FULL;
                end
                else if (ctr_reg == '0)
                begin
                    status_next = ST_INVALID;
                end
                else
                begin
                    status_next = ST_OK;
                    reg_ok      = 1'b1;
                end
            end
            OP_MODIFY:
            begin
                if (!mask_ok)
                begin
                    status_next = ST_INVALID;
                end
                else if (!tok_ok)
                begin
                    status_next = ST_STALE;
                end
                else
                begin
                    status_next = ST_OK;
                    mod_ok      = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                status_next = tok_ok ? ST_OK : ST_STALE;
                rem_ok      = tok_ok;
            end
            OP_CHECK:
            begin
                status_next = tok_ok ? ST_OK : ST_STALE;
            end
            default:
            begin
                status_next = ST_STALE;
            end
        endcase
    end

    assign entry_we   = cmd.commit && reg_ok;
    assign meta_we    = cmd.commit && (reg_ok || mod_ok);
    assign meta_waddr = reg_ok ? free_idx_reg : hit_idx_reg;

    // valid bits and generation counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ctr_reg   <= GEN_W'(1);
        end
        else if (cmd.commit)
        begin
            if (reg_ok)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                ctr_reg                 <= ctr_reg + GEN_W'(1);
            end
            if (rem_ok)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status            <= status_next;
            issued_generation <= reg_ok ? ctr_reg : '0;
        end
    end

`ifndef SYNTHESIS
    // an exhausted counter stays exhausted
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctr_reg == '0) |=> (ctr_reg == '0))
        else $error("generation counter left zero");

    // a registered slot is live after commit
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && reg_ok) |=> valid_reg[$past(free_idx_reg)])
        else $error("registered slot not marked valid");

    // a successful register never reuses a live descriptor
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && reg_ok) |-> (free_reg && !hit_reg && ctr_reg != '0))
        else $error("register committed without free slot");
`endif

endmodule

[design/generational_handle_table.sv]
// generational handle table: one operation at a time over a scan of all slots
// sequence: input transfer, scan of all slots, tail state, done state, then the result is registered
// a new item is taken only after the last result is committed; the scan reads one slot per cycle
//   from the descriptor ram read port
// reset: asynchronous active low; all slots free, generation counter at one,
//   slot rams are not cleared and are only read behind a set valid bit
module generational_handle_table (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         opcode,
    input  logic signed [ght_pkg::DESC_W-1:0]  descriptor,
    input  logic [ght_pkg::MASK_W-1:0]         interest_mask,
    input  logic [ght_pkg::TAG_W-1:0]          user_tag,
    input  logic [ght_pkg::GEN_W-1:0]          token_generation,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic [ght_pkg::GEN_W-1:0]          issued_generation
);

    import ght_pkg::*;

    ght_cmd_t  cmd;
    ght_stat_t stat;

    // sequencing
    ght_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // table storage, scan and result
    ght_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .opcode            (opcode),
        .descriptor        ($unsigned(descriptor)),
        .interest_mask     (interest_mask),
        .user_tag          (user_tag),
        .token_generation  (token_generation),
        .status            (status),
        .issued_generation (issued_generation)
    );

endmodule
